// File: hw/rtl/cartridge_rom_transfer_controller_unit_defines.svh
// Assertion macros used by the cartridge ROM transfer controller RTL.
`ifndef CARTRIDGE_ROM_TRANSFER_CONTROLLER_UNIT_DEFINES_SVH
`define CARTRIDGE_ROM_TRANSFER_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define CRTC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define CRTC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CRTC_ASSERT(lbl, clk, rst_n, prop, msg)

`define CRTC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: hw/rtl/crtc_pkg.sv
// Types and constants of the cartridge ROM transfer controller.
`default_nettype none

package crtc_pkg;

    localparam int S_TDATA_W = 168;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;
    localparam int CFG_INDEX_W = 2;
    localparam int COUNT_W = 15;

    typedef enum logic [1:0] {
        OP_CTRL = 2'd0,
        OP_CMD  = 2'd1,
        OP_READ = 2'd2,
        OP_IDLE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_DUMMY  = 3'd0,
        KIND_READ   = 3'd1,
        KIND_ID     = 3'd2,
        KIND_HEADER = 3'd3,
        KIND_NONE   = 3'd4
    } kind_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_CARD_PRESENT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IRQ_ENABLE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DMA_TO_ARM7  = 2'd2;

    localparam logic [63:0] CMD_READ_MASK  = 64'hff00_0000_00ff_ffff;
    localparam logic [63:0] CMD_READ_DATA  = 64'hb700_0000_0000_0000;
    localparam logic [63:0] CMD_CHIP_ID    = 64'hb800_0000_0000_0000;
    localparam logic [63:0] CMD_DUMMY      = 64'h9f00_0000_0000_0000;
    localparam logic [63:0] CMD_HEADER_ID  = 64'h9000_0000_0000_0000;
    localparam logic [7:0]  CMD_KEY1_OPC   = 8'h3c;
    localparam logic [31:0] CHIP_ID_WORD   = 32'h0000_1fc2;
    localparam logic [31:0] ROM_BASE       = 32'h0000_8000;
    localparam logic [31:0] ALL_ONES       = 32'hffff_ffff;
    localparam logic [COUNT_W-1:0] HEADER_MASK = 15'h0fff;
    localparam logic [2:0]  BLOCK_NONE     = 3'd0;
    localparam logic [2:0]  BLOCK_WORD     = 3'd7;

    typedef struct packed {
        logic [31:0] rom_word;
        logic [63:0] command_mask;
        logic [63:0] command_value;
        logic        start_req;
        logic [2:0]  blk_code;
        op_t         operation;
    } item_t;

    typedef struct packed {
        logic [31:0] fetch_address;
        logic        dma_request_arm9;
        logic        dma_request_arm7;
        logic        irq_pulse;
        logic        busy_res;
        logic        data_avail;
        logic [31:0] read_word;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/crtc_in_reg.sv
// Input register that holds one accepted transaction until the step logic takes it.
`default_nettype none

module crtc_in_reg (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire crtc_pkg::item_t in_item,
    input  wire logic            advance,
    output logic                 item_valid,
    output crtc_pkg::item_t      item
);

    logic            valid_reg;
    logic            valid_next;
    crtc_pkg::item_t item_reg;

    assign in_ready = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;

endmodule

`default_nettype wire

// File: hw/rtl/crtc_core.sv
// Controller state, command decode and per-transaction step logic.
`default_nettype none
`include "cartridge_rom_transfer_controller_unit_defines.svh"

module crtc_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [crtc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic                               cfg_data,
    input  wire logic                               step_en,
    input  wire crtc_pkg::item_t                    item,
    output crtc_pkg::result_t                       result
);

    logic [63:0]                    command_store_reg;
    logic [63:0]                    command_store_next;
    crtc_pkg::kind_t                command_kind_reg;
    crtc_pkg::kind_t                command_kind_next;
    logic [31:0]                    read_position_reg;
    logic [31:0]                    read_position_next;
    logic [crtc_pkg::COUNT_W-1:0]   byte_count_reg;
    logic [crtc_pkg::COUNT_W-1:0]   byte_count_next;
    logic [crtc_pkg::COUNT_W-1:0]   byte_total_reg;
    logic [crtc_pkg::COUNT_W-1:0]   byte_total_next;
    logic                           start_flag_reg;
    logic                           start_flag_next;
    logic                           ready_flag_reg;
    logic                           ready_flag_next;
    logic                           key1_mode_reg;
    logic                           key1_mode_next;
    logic                           card_present_reg;
    logic                           irq_enable_reg;
    logic                           dma_to_arm7_reg;

    logic [63:0]                    cmd_swapped;
    logic                           dec_hit;
    crtc_pkg::kind_t                dec_kind;
    logic                           dec_load_pos;
    logic                           dec_key1;
    logic [crtc_pkg::COUNT_W-1:0]   size_total;
    logic [crtc_pkg::COUNT_W-1:0]   count_inc;
    logic [31:0]                    cur_position;
    logic [31:0]                    next_position;
    logic [31:0]                    data_word;
    logic                           irq;
    logic                           dma;
    logic [31:0]                    fetch;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            cmd_swapped[8*i +: 8] = command_store_reg[8*(7-i) +: 8];
        end
    end

    always_comb
    begin
        dec_hit = 1'b1;
        dec_kind = command_kind_reg;
        dec_load_pos = 1'b0;
        dec_key1 = 1'b0;
        priority if ((cmd_swapped & crtc_pkg::CMD_READ_MASK) == crtc_pkg::CMD_READ_DATA)
        begin
            dec_kind = crtc_pkg::KIND_READ;
            dec_load_pos = 1'b1;
        end
        else if (cmd_swapped == crtc_pkg::CMD_CHIP_ID)
        begin
            dec_kind = crtc_pkg::KIND_ID;
        end
        else if (cmd_swapped == crtc_pkg::CMD_DUMMY)
        begin
            dec_kind = crtc_pkg::KIND_DUMMY;
        end
        else if (cmd_swapped == 64'd0)
        begin
            dec_kind = crtc_pkg::KIND_HEADER;
        end
        else if (cmd_swapped == crtc_pkg::CMD_HEADER_ID)
        begin
            dec_kind = crtc_pkg::KIND_ID;
        end
        else if (cmd_swapped[63:56] == crtc_pkg::CMD_KEY1_OPC)
        begin
            dec_kind = crtc_pkg::KIND_NONE;
            dec_key1 = 1'b1;
        end
        else
        begin
            dec_hit = 1'b0;
        end
    end

    always_comb
    begin
        priority if (item.blk_code == crtc_pkg::BLOCK_NONE)
        begin
            size_total = '0;
        end
        else if (item.blk_code == crtc_pkg::BLOCK_WORD)
        begin
            size_total = crtc_pkg::COUNT_W'(4);
        end
        else
        begin
            size_total = crtc_pkg::COUNT_W'(15'h0100 << item.blk_code);
        end
    end

    assign cur_position = (read_position_reg < crtc_pkg::ROM_BASE)
        ? (crtc_pkg::ROM_BASE | {23'd0, read_position_reg[8:0]})
        : read_position_reg;
    assign next_position = (read_position_next < crtc_pkg::ROM_BASE)
        ? (crtc_pkg::ROM_BASE | {23'd0, read_position_next[8:0]})
        : read_position_next;
    assign count_inc = byte_count_reg + crtc_pkg::COUNT_W'(4);

    always_comb
    begin
        command_store_next = command_store_reg;
        command_kind_next = command_kind_reg;
        read_position_next = read_position_reg;
        byte_count_next = byte_count_reg;
        byte_total_next = byte_total_reg;
        start_flag_next = start_flag_reg;
        ready_flag_next = ready_flag_reg;
        key1_mode_next = key1_mode_reg;
        data_word = crtc_pkg::ALL_ONES;
        irq = 1'b0;
        dma = 1'b0;
        if (step_en)
        begin
            unique case (item.operation)
                crtc_pkg::OP_CTRL:
                begin
                    start_flag_next = item.start_req;
                    if (!start_flag_reg && item.start_req)
                    begin
                        byte_total_next = size_total;
                        if (card_present_reg && !key1_mode_reg && dec_hit)
                        begin
                            command_kind_next = dec_kind;
                            if (dec_load_pos)
                            begin
                                read_position_next = cmd_swapped[55:24];
                            end
                            if (dec_key1)
                            begin
                                key1_mode_next = 1'b1;
                            end
                        end
                        if (size_total == '0)
                        begin
                            ready_flag_next = 1'b0;
                            start_flag_next = 1'b0;
                            irq = irq_enable_reg;
                        end
                        else
                        begin
                            byte_count_next = '0;
                            ready_flag_next = 1'b1;
                            dma = 1'b1;
                        end
                    end
                end
                crtc_pkg::OP_CMD:
                begin
                    command_store_next = (command_store_reg & ~item.command_mask)
                        | (item.command_value & item.command_mask);
                end
                crtc_pkg::OP_READ:
                begin
                    if (ready_flag_reg)
                    begin
                        if (card_present_reg)
                        begin
                            unique case (command_kind_reg)
                                crtc_pkg::KIND_READ:
                                begin
                                    read_position_next = cur_position;
                                    data_word = item.rom_word;
                                end
                                crtc_pkg::KIND_ID:
                                begin
                                    data_word = crtc_pkg::CHIP_ID_WORD;
                                end
                                crtc_pkg::KIND_HEADER:
                                begin
                                    data_word = item.rom_word;
                                end
                                default:
                                begin
                                    data_word = crtc_pkg::ALL_ONES;
                                end
                            endcase
                        end
                        byte_count_next = count_inc;
                        if (count_inc == byte_total_reg)
                        begin
                            ready_flag_next = 1'b0;
                            start_flag_next = 1'b0;
                            irq = irq_enable_reg;
                        end
                        else
                        begin
                            dma = 1'b1;
                        end
                    end
                end
                crtc_pkg::OP_IDLE:
                begin
                    data_word = crtc_pkg::ALL_ONES;
                end
                default:
                begin
                    data_word = crtc_pkg::ALL_ONES;
                end
            endcase
        end
    end

    always_comb
    begin
        fetch = '0;
        if (ready_flag_next && card_present_reg)
        begin
            if (command_kind_next == crtc_pkg::KIND_READ)
            begin
                fetch = next_position + {17'd0, byte_count_next};
            end
            else if (command_kind_next == crtc_pkg::KIND_HEADER)
            begin
                fetch = {17'd0, byte_count_next & crtc_pkg::HEADER_MASK};
            end
        end
    end

    always_comb
    begin
        result.read_word = data_word;
        result.data_avail = ready_flag_next;
        result.busy_res = start_flag_next;
        result.irq_pulse = irq;
        result.dma_request_arm7 = dma && dma_to_arm7_reg;
        result.dma_request_arm9 = dma && !dma_to_arm7_reg;
        result.fetch_address = fetch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_store_reg <= '0;
            command_kind_reg <= crtc_pkg::KIND_DUMMY;
            read_position_reg <= '0;
            byte_count_reg <= '0;
            byte_total_reg <= '0;
            start_flag_reg <= 1'b0;
            ready_flag_reg <= 1'b0;
            key1_mode_reg <= 1'b0;
        end
        else
        begin
            command_store_reg <= command_store_next;
            command_kind_reg <= command_kind_next;
            read_position_reg <= read_position_next;
            byte_count_reg <= byte_count_next;
            byte_total_reg <= byte_total_next;
            start_flag_reg <= start_flag_next;
            ready_flag_reg <= ready_flag_next;
            key1_mode_reg <= key1_mode_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            card_present_reg <= 1'b0;
            irq_enable_reg <= 1'b0;
            dma_to_arm7_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == crtc_pkg::CFG_CARD_PRESENT)
            begin
                card_present_reg <= cfg_data;
            end
            if (cfg_index == crtc_pkg::CFG_IRQ_ENABLE)
            begin
                irq_enable_reg <= cfg_data;
            end
            if (cfg_index == crtc_pkg::CFG_DMA_TO_ARM7)
            begin
                dma_to_arm7_reg <= cfg_data;
            end
        end
    end

    // A transfer in progress always has words left to deliver.
    `CRTC_ASSERT(a_ready_count, clk, rst_n, ready_flag_reg |-> (byte_count_reg != byte_total_reg), "ready with count at total")
    `CRTC_ASSERT(a_count_aligned, clk, rst_n, byte_count_reg[1:0] == 2'b00, "byte count not word aligned")
    `CRTC_ASSERT(a_key1_sticky, clk, rst_n, key1_mode_reg |=> key1_mode_reg, "key1 mode left without reset")
    `CRTC_ASSERT(a_ready_rise, clk, rst_n, $rose(ready_flag_reg) |-> (byte_count_reg == '0), "transfer began with nonzero count")

endmodule

`default_nettype wire

// File: hw/rtl/crtc_out_reg.sv
// Result register that holds one result transaction until the master side takes it.
`default_nettype none

module crtc_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire crtc_pkg::result_t load_result,
    output logic                   free,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output crtc_pkg::result_t      out_result
);

    logic              valid_reg;
    logic              valid_next;
    crtc_pkg::result_t result_reg;

    assign free = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid = valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

// File: hw/rtl/cartridge_rom_transfer_controller_unit.sv
// Top level of the cartridge ROM transfer controller.
//
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser operation, tdata item fields
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata result fields
// cfg       in         cfg_we (no back-pressure)     cfg_index, cfg_data
//
// One transaction a cycle is sustained while the master side takes every result; each
// goes from the input register through the step logic into the result register.
// The state update and result are computed in the single cycle the input register
// hands a transaction to the result register.
// Reset clears all control state; no clearing pass is needed.
// A stall on the master side holds the result register and then the input register.
`default_nettype none

module cartridge_rom_transfer_controller_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // Fields from bit 0: blk_code, start_req, command_value, command_mask, rom_word.
    input  wire logic [crtc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // Fields from bit 0: operation.
    input  wire logic [crtc_pkg::S_TUSER_W-1:0]      s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // Fields from bit 0: read_word, data_avail, busy_res, irq_pulse,
    // dma_request_arm7, dma_request_arm9, fetch_address.
    output logic [crtc_pkg::M_TDATA_W-1:0]           m_axis_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [crtc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic                                cfg_data
);

    crtc_pkg::item_t   in_item;
    crtc_pkg::item_t   item;
    logic              item_valid;
    logic              out_free;
    logic              advance;
    crtc_pkg::result_t step_result;
    crtc_pkg::result_t out_result;

    always_comb
    begin
        in_item.operation = crtc_pkg::op_t'(s_axis_tuser[1:0]);
        in_item.blk_code = s_axis_tdata[2:0];
        in_item.start_req = s_axis_tdata[3];
        in_item.command_value = s_axis_tdata[67:4];
        in_item.command_mask = s_axis_tdata[131:68];
        in_item.rom_word = s_axis_tdata[163:132];
    end

    assign advance = item_valid && out_free;

    crtc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    crtc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_en   (advance),
        .item      (item),
        .result    (step_result)
    );

    crtc_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .load_result (step_result),
        .free        (out_free),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_result  (out_result)
    );

    assign m_axis_tdata = {3'd0,
                           out_result.fetch_address,
                           out_result.dma_request_arm9,
                           out_result.dma_request_arm7,
                           out_result.irq_pulse,
                           out_result.busy_res,
                           out_result.data_avail,
                           out_result.read_word};

endmodule

`default_nettype wire
